@@ sv/modexp_pkg.sv @@
// Shared types for the modular exponentiation core: controller states, commands and status.
package modexp_pkg;

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_LOAD   = 6'b000010,
        ST_REDUCE = 6'b000100,
        ST_STEP   = 6'b001000,
        ST_MULT   = 6'b010000,
        ST_SQUARE = 6'b100000
    } state_t;

    typedef enum logic [1:0] {
        OP_REDUCE = 2'd0,
        OP_MULT   = 2'd1,
        OP_SQUARE = 2'd2,
        OP_EMIT   = 2'd3
    } op_t;

    typedef struct packed {
        logic load;
        logic mul_start;
        op_t  mul_op;
        logic write_x;
        logic write_res;
        logic shift_exp;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic mul_done;
        logic exp_zero;
        logic exp_lsb;
        logic out_free;
    } status_t;

endpackage

@@ sv/modexp_if.sv @@
// Valid/ready channel interfaces for the input and result items.
interface modexp_in_if #(
    parameter int WORD_BITS = 32
) ();
    logic                 valid;
    logic                 ready;
    logic [WORD_BITS-1:0] base;
    logic [WORD_BITS-1:0] exponent;

    modport source (output valid, output base, output exponent, input ready);
    modport sink   (input valid, input base, input exponent, output ready);
endinterface

interface modexp_out_if #(
    parameter int WORD_BITS = 32
) ();
    logic                 valid;
    logic                 ready;
    logic [WORD_BITS-1:0] result;

    modport source (output valid, output result, input ready);
    modport sink   (input valid, input result, output ready);
endinterface

@@ sv/modexp_mulmod.sv @@
// Bit-serial interleaved modular multiplier, one multiplier bit per cycle.
module modexp_mulmod #(
    parameter int WORD_BITS = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [WORD_BITS-1:0] addend,
    input  logic [WORD_BITS-1:0] scan,
    input  logic [WORD_BITS-1:0] modulus,
    output logic                 done,
    output logic [WORD_BITS-1:0] product
);

    localparam int CW = $clog2(WORD_BITS);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [CW-1:0]        cnt_reg, cnt_next;
    logic [WORD_BITS-1:0] acc_reg, acc_next;
    logic [WORD_BITS-1:0] addend_reg, addend_next;
    logic [WORD_BITS-1:0] scan_reg, scan_next;

    logic [WORD_BITS:0]   dbl;
    logic [WORD_BITS-1:0] dbl_red;
    logic [WORD_BITS:0]   sum;
    logic [WORD_BITS-1:0] sum_red;
    logic                 mod_on;

    assign mod_on = (modulus != '0);

    always_comb
    begin
        dbl = {acc_reg, 1'b0};
        if (mod_on && (dbl >= {1'b0, modulus}))
        begin
            dbl_red = WORD_BITS'(dbl - {1'b0, modulus});
        end
        else
        begin
            dbl_red = dbl[WORD_BITS-1:0];
        end
        sum = {1'b0, dbl_red} + (scan_reg[WORD_BITS-1] ? {1'b0, addend_reg} : '0);
        if (mod_on && (sum >= {1'b0, modulus}))
        begin
            sum_red = WORD_BITS'(sum - {1'b0, modulus});
        end
        else
        begin
            sum_red = sum[WORD_BITS-1:0];
        end
    end

    always_comb
    begin
        busy_next   = busy_reg;
        done_next   = 1'b0;
        cnt_next    = cnt_reg;
        acc_next    = acc_reg;
        addend_next = addend_reg;
        scan_next   = scan_reg;
        if (start)
        begin
            busy_next   = 1'b1;
            cnt_next    = CW'(WORD_BITS - 1);
            acc_next    = '0;
            addend_next = addend;
            scan_next   = scan;
        end
        else if (busy_reg)
        begin
            acc_next  = sum_red;
            scan_next = {scan_reg[WORD_BITS-2:0], 1'b0};
            cnt_next  = cnt_reg - CW'(1);
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg    <= acc_next;
        addend_reg <= addend_next;
        scan_reg   <= scan_next;
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

@@ sv/modexp_datapath.sv @@
// Datapath: modulus register, operand registers, exponent shifter and result register.
module modexp_datapath #(
    parameter int WORD_BITS = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [WORD_BITS-1:0] cfg_wdata,
    input  logic [WORD_BITS-1:0] base,
    input  logic [WORD_BITS-1:0] exponent,
    input  logic                 out_ready,
    output logic                 out_valid,
    output logic [WORD_BITS-1:0] result,
    input  modexp_pkg::cmd_t     cmd,
    output modexp_pkg::status_t  status
);

    logic [WORD_BITS-1:0] modulus_reg;
    logic [WORD_BITS-1:0] x_reg, x_next;
    logic [WORD_BITS-1:0] res_reg, res_next;
    logic [WORD_BITS-1:0] exp_reg, exp_next;
    logic [WORD_BITS-1:0] out_reg, out_next;
    logic                 out_valid_reg, out_valid_next;
    logic [WORD_BITS-1:0] mul_addend;
    logic [WORD_BITS-1:0] mul_scan;
    logic [WORD_BITS-1:0] product;
    logic                 mul_done;

    always_comb
    begin
        unique case (cmd.mul_op)
            modexp_pkg::OP_REDUCE:
            begin
                mul_addend = WORD_BITS'(1);
                mul_scan   = x_reg;
            end
            modexp_pkg::OP_MULT:
            begin
                mul_addend = res_reg;
                mul_scan   = x_reg;
            end
            default:
            begin
                mul_addend = x_reg;
                mul_scan   = x_reg;
            end
        endcase
    end

    modexp_mulmod #(
        .WORD_BITS(WORD_BITS)
    ) u_mulmod (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cmd.mul_start),
        .addend  (mul_addend),
        .scan    (mul_scan),
        .modulus (modulus_reg),
        .done    (mul_done),
        .product (product)
    );

    always_comb
    begin
        x_next         = x_reg;
        res_next       = res_reg;
        exp_next       = exp_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !out_ready;
        if (cmd.load)
        begin
            x_next   = base;
            exp_next = exponent;
            if ((exponent != '0) && (modulus_reg == WORD_BITS'(1)))
            begin
                res_next = '0;
            end
            else
            begin
                res_next = WORD_BITS'(1);
            end
        end
        if (cmd.write_x)
        begin
            x_next = product;
        end
        if (cmd.write_res)
        begin
            res_next = product;
        end
        if (cmd.shift_exp)
        begin
            exp_next = exp_reg >> 1;
        end
        if (cmd.emit)
        begin
            out_next       = res_reg;
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg   <= WORD_BITS'(1);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                modulus_reg <= cfg_wdata;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg   <= x_next;
        res_reg <= res_next;
        exp_reg <= exp_next;
        out_reg <= out_next;
    end

    assign out_valid       = out_valid_reg;
    assign result          = out_reg;
    assign status.mul_done = mul_done;
    assign status.exp_zero = (exp_reg == '0);
    assign status.exp_lsb  = exp_reg[0];
    assign status.out_free = !out_valid_reg || out_ready;

endmodule

@@ sv/modexp_ctrl.sv @@
// Controller state machine that sequences reduction, multiply and square steps.
module modexp_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_exp_zero,
    output logic                in_ready,
    input  modexp_pkg::status_t status,
    output modexp_pkg::cmd_t    cmd
);

    modexp_pkg::state_t state_reg, state_next;
    logic               emit_pending;

    assign in_ready     = (state_reg == modexp_pkg::ST_IDLE);
    assign emit_pending = (state_reg == modexp_pkg::ST_STEP) && status.exp_zero;

    always_comb
    begin
        state_next    = state_reg;
        cmd           = '0;
        cmd.mul_op    = modexp_pkg::OP_REDUCE;
        unique case (state_reg)
            modexp_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    if (in_exp_zero)
                    begin
                        state_next = modexp_pkg::ST_STEP;
                    end
                    else
                    begin
                        state_next = modexp_pkg::ST_LOAD;
                    end
                end
            end
            modexp_pkg::ST_LOAD:
            begin
                cmd.mul_start = 1'b1;
                cmd.mul_op    = modexp_pkg::OP_REDUCE;
                state_next    = modexp_pkg::ST_REDUCE;
            end
            modexp_pkg::ST_REDUCE:
            begin
                cmd.mul_op = modexp_pkg::OP_REDUCE;
                if (status.mul_done)
                begin
                    cmd.write_x = 1'b1;
                    state_next  = modexp_pkg::ST_STEP;
                end
            end
            modexp_pkg::ST_STEP:
            begin
                if (emit_pending)
                begin
                    cmd.mul_op = modexp_pkg::OP_EMIT;
                    if (status.out_free)
                    begin
                        cmd.emit   = 1'b1;
                        state_next = modexp_pkg::ST_IDLE;
                    end
                end
                else if (status.exp_lsb)
                begin
                    cmd.mul_start = 1'b1;
                    cmd.mul_op    = modexp_pkg::OP_MULT;
                    state_next    = modexp_pkg::ST_MULT;
                end
                else
                begin
                    cmd.mul_start = 1'b1;
                    cmd.mul_op    = modexp_pkg::OP_SQUARE;
                    state_next    = modexp_pkg::ST_SQUARE;
                end
            end
            modexp_pkg::ST_MULT:
            begin
                cmd.mul_op = modexp_pkg::OP_MULT;
                if (status.mul_done)
                begin
                    cmd.write_res = 1'b1;
                    cmd.mul_start = 1'b1;
                    cmd.mul_op    = modexp_pkg::OP_SQUARE;
                    state_next    = modexp_pkg::ST_SQUARE;
                end
            end
            modexp_pkg::ST_SQUARE:
            begin
                cmd.mul_op = modexp_pkg::OP_SQUARE;
                if (status.mul_done)
                begin
                    cmd.write_x   = 1'b1;
                    cmd.shift_exp = 1'b1;
                    state_next    = modexp_pkg::ST_STEP;
                end
            end
            default:
            begin
                state_next = modexp_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= modexp_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

@@ sv/modular_exponentiation_core.sv @@
// Top level of the modular exponentiation core: controller, datapath and channel hookup.
//
// The core computes base to the power exponent modulo a modulus register by
// right-to-left square-and-multiply. The modulus is written through cfg_we and
// cfg_wdata; the user must write it only while the core is idle (not enforced by
// the core). A modulus of zero means arithmetic modulo two to the word width.
// Items enter on in_ch and results leave on out_ch, both valid/ready channels.
// One item is worked on at a time. An exponent of zero offers 1 on out_ch with
// no multiplication, once the output register is free. Otherwise the base is
// first reduced by the modulus, and each exponent bit up to the highest set bit
// costs one square plus one multiply when the bit is set, all on a single
// bit-serial modular multiplier that retires one bit per cycle; the result is
// offered once the exponent has shifted to zero and the output register is free.
// A finished result sits in an output register, so a new item is accepted while
// the receiver stalls; the core only waits when a second result is ready
// before the first has been taken.
// Reset sets the modulus to 1, empties the output register and returns the
// controller to idle.
module modular_exponentiation_core #(
    parameter int WORD_BITS = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [WORD_BITS-1:0] cfg_wdata,
    modexp_in_if.sink            in_ch,
    modexp_out_if.source         out_ch
);

    modexp_pkg::cmd_t    cmd;
    modexp_pkg::status_t status;

    modexp_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_ch.valid),
        .in_exp_zero (in_ch.exponent == '0),
        .in_ready    (in_ch.ready),
        .status      (status),
        .cmd         (cmd)
    );

    modexp_datapath #(
        .WORD_BITS(WORD_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .base      (in_ch.base),
        .exponent  (in_ch.exponent),
        .out_ready (out_ch.ready),
        .out_valid (out_ch.valid),
        .result    (out_ch.result),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

@@ sv/modexp_checker.sv @@
// Port-level checker for the modular exponentiation core and its bind statement.
module modexp_checker #(
    parameter int WORD_BITS = 32
) (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 in_valid,
    input logic                 in_ready,
    input logic                 out_valid,
    input logic                 out_ready,
    input logic [WORD_BITS-1:0] result
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(result))
        else $error("Stalled result item changed or dropped.");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("Core accepted a second item while one is in progress.");

    a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !$rose(out_valid))
        else $error("Result item appeared in the cycle after acceptance.");

    a_reset_empty: assert property (@(posedge clk)
        !rst_n |=> !out_valid && in_ready)
        else $error("Core not idle and empty after a reset cycle.");

endmodule

bind modular_exponentiation_core modexp_checker #(
    .WORD_BITS(WORD_BITS)
) u_modexp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .result    (out_ch.result)
);
